### hw/rtl/lipc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lipc_pkg;
   localparam int MAX_COLUMNS_DEF = 4096;
   localparam int MAX_RINGS_DEF   = 128;
   localparam int CORDIC_STEPS    = 18;
   localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic signed [25:0] OUT_LIMIT = 26'sd16777215;
   localparam int ADDR_W = 5;

   localparam logic [ADDR_W-1:0] REG_MIN_RANGE = 5'd0;
   localparam logic [ADDR_W-1:0] REG_MAX_RANGE = 5'd4;
   localparam logic [ADDR_W-1:0] REG_MIN_INTEN = 5'd8;
   localparam logic [ADDR_W-1:0] REG_COLUMNS   = 5'd12;
   localparam logic [ADDR_W-1:0] REG_RINGS     = 5'd16;

   // rotation angle per cell, units of pi/2^19
   function automatic logic signed [21:0] atan_step(input int i);
      logic signed [21:0] r;
      r = '0;
      case (i)
         0: r = 22'sd131072;  1: r = 22'sd77376;  2: r = 22'sd40884;
         3: r = 22'sd20753;   4: r = 22'sd10417;  5: r = 22'sd5213;
         6: r = 22'sd2607;    7: r = 22'sd1304;   8: r = 22'sd652;
         9: r = 22'sd326;    10: r = 22'sd163;   11: r = 22'sd81;
         12: r = 22'sd41;    13: r = 22'sd20;    14: r = 22'sd10;
         15: r = 22'sd5;     16: r = 22'sd3;     17: r = 22'sd1;
         default: r = '0;
      endcase
      return r;
   endfunction

   typedef struct packed {
      logic signed [32:0] px;
      logic signed [32:0] py;
      logic signed [21:0] pz;
      logic signed [32:0] yx;
      logic signed [32:0] yy;
      logic signed [21:0] yz;
   } cordic_type;

   typedef struct packed {
      logic        pflip;
      logic        yflip;
      logic [23:0] range;
      logic [15:0] inten;
      logic [6:0]  ring;
   } side_type;
endpackage
`default_nettype wire

### hw/rtl/lipc_cell.sv
`timescale 1ns / 1ps
`default_nettype none
module lipc_cell import lipc_pkg::*; #(
   parameter int STEP = 0
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       en,
   input  wire logic       vld_in,
   input  wire cordic_type rot_in,
   input  wire side_type   side_in,
   output logic            vld_out,
   output cordic_type      rot_out,
   output side_type        side_out
);
   logic       vld_ff;
   cordic_type rot_ff, rot_in_c;
   side_type   side_ff;

   // one micro-rotation for pitch and yaw side by side
   always_comb begin
      rot_in_c = rot_in;
      if (!rot_in.pz[21]) begin
         rot_in_c.px = rot_in.px - (rot_in.py >>> STEP);
         rot_in_c.py = rot_in.py + (rot_in.px >>> STEP);
         rot_in_c.pz = rot_in.pz - atan_step(STEP);
      end else begin
         rot_in_c.px = rot_in.px + (rot_in.py >>> STEP);
         rot_in_c.py = rot_in.py - (rot_in.px >>> STEP);
         rot_in_c.pz = rot_in.pz + atan_step(STEP);
      end
      if (!rot_in.yz[21]) begin
         rot_in_c.yx = rot_in.yx - (rot_in.yy >>> STEP);
         rot_in_c.yy = rot_in.yy + (rot_in.yx >>> STEP);
         rot_in_c.yz = rot_in.yz - atan_step(STEP);
      end else begin
         rot_in_c.yx = rot_in.yx + (rot_in.yy >>> STEP);
         rot_in_c.yy = rot_in.yy - (rot_in.yx >>> STEP);
         rot_in_c.yz = rot_in.yz + atan_step(STEP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else if (en) vld_ff <= vld_in;
      if (en) begin
         rot_ff  <= rot_in_c;
         side_ff <= side_in;
      end
   end

   assign vld_out  = vld_ff;
   assign rot_out  = rot_ff;
   assign side_out = side_ff;
endmodule
`default_nettype wire

### hw/rtl/lidar_interp_point_converter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Converts one lidar sample per clock: bilinear range, averaged intensity and
// window test in a four-stage front end, then a chain of 18 CORDIC cells that
// rotate pitch and yaw together, then four multiply stages to x, y, z. That is
// 26 register stages. Dropped points give no result. The pipeline stalls as a
// whole when the result register is full and not taken, so throughput is one
// transaction per cycle while results are taken.
module lidar_interp_point_converter_core import lipc_pkg::*; #(
   parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
   parameter int MAX_RINGS   = MAX_RINGS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [23:0]        req_range_a,
   input  wire logic [23:0]        req_range_b,
   input  wire logic [23:0]        req_range_c,
   input  wire logic [23:0]        req_range_d,
   input  wire logic [15:0]        req_intensity_a,
   input  wire logic [15:0]        req_intensity_b,
   input  wire logic [15:0]        req_intensity_c,
   input  wire logic [15:0]        req_intensity_d,
   input  wire logic [15:0]        req_horiz_frac,
   input  wire logic [15:0]        req_vert_frac,
   input  wire logic signed [15:0] req_yaw_angle,
   input  wire logic signed [15:0] req_pitch_angle,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic signed [24:0]      rsp_point_x,
   output logic signed [24:0]      rsp_point_y,
   output logic signed [24:0]      rsp_point_z,
   output logic [15:0]             rsp_point_intensity,
   output logic [6:0]              rsp_ring_number,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [ADDR_W-1:0]  paddr,
   input  wire logic [31:0]        pwdata,
   output logic [31:0]             prdata,
   output logic                    pready
);
   localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

   logic [23:0] min_range_ff, max_range_ff;
   logic [15:0] min_inten_ff;
   logic [12:0] columns_ff;
   logic [7:0]  rings_ff;
   logic        wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_range_ff <= '0;
         max_range_ff <= 24'hFFFFFF;
         min_inten_ff <= '0;
         columns_ff   <= 13'd4096;
         rings_ff     <= 8'd16;
      end else if (wr_en) begin
         case (paddr)
            REG_MIN_RANGE: min_range_ff <= pwdata[23:0];
            REG_MAX_RANGE: max_range_ff <= pwdata[23:0];
            REG_MIN_INTEN: min_inten_ff <= pwdata[15:0];
            REG_COLUMNS:   columns_ff   <= pwdata[12:0];
            REG_RINGS:     rings_ff     <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr)
         REG_MIN_RANGE: prdata = {8'd0, min_range_ff};
         REG_MAX_RANGE: prdata = {8'd0, max_range_ff};
         REG_MIN_INTEN: prdata = {16'd0, min_inten_ff};
         REG_COLUMNS:   prdata = {19'd0, columns_ff};
         REG_RINGS:     prdata = {24'd0, rings_ff};
         default:       prdata = '0;
      endcase
   end

   // global stall: everything advances unless the result register holds a result that is not taken
   logic adv;
   logic out_vld_ff;
   assign adv       = !out_vld_ff || rsp_ready;
   assign req_ready = adv;
   logic acc;
   assign acc = req_valid && req_ready;

   // column / ring counters
   logic [16:0] col_lim, ring_lim;
   logic [16:0] col_ff, ring_ff;
   always_comb begin
      col_lim = (columns_ff == 13'd0) ? 17'd1 : {4'd0, columns_ff};
      if (col_lim > 17'(MAX_COLUMNS)) col_lim = 17'(MAX_COLUMNS);
      ring_lim = (rings_ff == 8'd0) ? 17'd1 : {9'd0, rings_ff};
      if (ring_lim > 17'(MAX_RINGS)) ring_lim = 17'(MAX_RINGS);
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         ring_ff <= '0;
      end else if (acc) begin
         if (col_ff + 17'd1 >= col_lim) begin
            col_ff <= '0;
            if (ring_ff + 17'd1 >= ring_lim) ring_ff <= '0;
            else ring_ff <= {10'd0, 7'(ring_ff + 17'd1)};
         end else begin
            col_ff <= {(17-CW)'(0), CW'(col_ff + 17'd1)} & 17'hFFF;
         end
      end
   end

   // stage 1: horizontal lerp products
   logic        s1_vld_ff;
   logic [40:0] s1_ta_ff, s1_tc_ff, s1_bb_ff, s1_bd_ff;
   logic [16:0] s1_v_ff;
   logic [17:0] s1_isum_ff;
   logic [15:0] s1_yaw_ff, s1_pitch_ff;
   logic [6:0]  s1_ring_ff;
   logic [16:0] hinv;
   assign hinv = 17'h10000 - {1'b0, req_horiz_frac};
   always_ff @(posedge clock) begin
      if (reset) s1_vld_ff <= 1'b0;
      else if (adv) s1_vld_ff <= acc;
      if (adv) begin
         s1_ta_ff <= 41'(hinv * req_range_a);
         s1_tc_ff <= 41'(req_horiz_frac * req_range_c);
         s1_bb_ff <= 41'(hinv * req_range_b);
         s1_bd_ff <= 41'(req_horiz_frac * req_range_d);
         s1_v_ff  <= {1'b0, req_vert_frac};
         s1_isum_ff <= 18'(req_intensity_a) + 18'(req_intensity_b)
                     + 18'(req_intensity_c) + 18'(req_intensity_d);
         s1_yaw_ff   <= req_yaw_angle;
         s1_pitch_ff <= req_pitch_angle;
         s1_ring_ff  <= ring_ff[6:0];
      end
   end

   // stage 2: sums
   logic        s2_vld_ff;
   logic [40:0] s2_top_ff, s2_bot_ff;
   logic [16:0] s2_v_ff;
   logic [15:0] s2_inten_ff, s2_yaw_ff, s2_pitch_ff;
   logic [6:0]  s2_ring_ff;
   always_ff @(posedge clock) begin
      if (reset) s2_vld_ff <= 1'b0;
      else if (adv) s2_vld_ff <= s1_vld_ff;
      if (adv) begin
         s2_top_ff <= s1_ta_ff + s1_tc_ff;
         s2_bot_ff <= s1_bb_ff + s1_bd_ff;
         s2_v_ff   <= s1_v_ff;
         s2_inten_ff <= s1_isum_ff[17:2];
         s2_yaw_ff <= s1_yaw_ff;
         s2_pitch_ff <= s1_pitch_ff;
         s2_ring_ff <= s1_ring_ff;
      end
   end

   // stage 3: vertical products (41x17)
   logic        s3_vld_ff;
   logic [57:0] s3_t_ff, s3_b_ff;
   logic [15:0] s3_inten_ff, s3_yaw_ff, s3_pitch_ff;
   logic [6:0]  s3_ring_ff;
   logic [16:0] vinv;
   assign vinv = 17'h10000 - s2_v_ff;
   always_ff @(posedge clock) begin
      if (reset) s3_vld_ff <= 1'b0;
      else if (adv) s3_vld_ff <= s2_vld_ff;
      if (adv) begin
         s3_t_ff <= 58'(vinv) * 58'(s2_top_ff);
         s3_b_ff <= 58'(s2_v_ff) * 58'(s2_bot_ff);
         s3_inten_ff <= s2_inten_ff;
         s3_yaw_ff <= s2_yaw_ff;
         s3_pitch_ff <= s2_pitch_ff;
         s3_ring_ff <= s2_ring_ff;
      end
   end

   // stage 4: range, keep test, angle fold, CORDIC seed
   logic [57:0] rsum;
   logic [23:0] range_c;
   logic        keep;
   logic signed [16:0] pa, ya;
   logic        pflip, yflip;
   assign rsum    = s3_t_ff + s3_b_ff;
   assign range_c = rsum[55:32];
   assign keep = s3_vld_ff && (min_range_ff < range_c) && (range_c < max_range_ff)
              && (s3_inten_ff >= min_inten_ff);
   always_comb begin
      pa = 17'(signed'(s3_pitch_ff));
      pflip = 1'b0;
      if (pa > 17'sd16384) begin pa = pa - 17'sd32768; pflip = 1'b1; end
      else if (pa < -17'sd16384) begin pa = pa + 17'sd32768; pflip = 1'b1; end
      ya = 17'(signed'(s3_yaw_ff));
      yflip = 1'b0;
      if (ya > 17'sd16384) begin ya = ya - 17'sd32768; yflip = 1'b1; end
      else if (ya < -17'sd16384) begin ya = ya + 17'sd32768; yflip = 1'b1; end
   end

   logic       s4_vld_ff;
   cordic_type s4_rot_ff;
   side_type   s4_side_ff;
   always_ff @(posedge clock) begin
      if (reset) s4_vld_ff <= 1'b0;
      else if (adv) s4_vld_ff <= keep;
      if (adv) begin
         s4_rot_ff.px <= CORDIC_GAIN;
         s4_rot_ff.py <= '0;
         s4_rot_ff.pz <= {pa[16], pa, 4'd0};
         s4_rot_ff.yx <= CORDIC_GAIN;
         s4_rot_ff.yy <= '0;
         s4_rot_ff.yz <= {ya[16], ya, 4'd0};
         s4_side_ff <= '{pflip: pflip, yflip: yflip, range: range_c,
                         inten: s3_inten_ff, ring: s3_ring_ff};
      end
   end

   // chain of CORDIC cells, stepping together with the rest of the pipe
   logic       c_vld [CORDIC_STEPS+1];
   cordic_type c_rot [CORDIC_STEPS+1];
   side_type   c_side[CORDIC_STEPS+1];
   assign c_vld[0]  = s4_vld_ff;
   assign c_rot[0]  = s4_rot_ff;
   assign c_side[0] = s4_side_ff;

   genvar g;
   generate
      for (g = 0; g < CORDIC_STEPS; g++) begin : g_cell
         lipc_cell #(.STEP(g)) u_cell (
            .clock(clock), .reset(reset), .en(adv),
            .vld_in(c_vld[g]), .rot_in(c_rot[g]), .side_in(c_side[g]),
            .vld_out(c_vld[g+1]), .rot_out(c_rot[g+1]), .side_out(c_side[g+1]));
      end
   endgenerate

   // post stage A: range * cos pitch, range * sin pitch
   function automatic logic signed [25:0] sat(input logic signed [63:0] v);
      if (v > 64'(OUT_LIMIT)) return OUT_LIMIT;
      if (v < -64'(OUT_LIMIT)) return -OUT_LIMIT;
      return 26'(v);
   endfunction
   function automatic logic signed [63:0] rnd(input logic signed [63:0] p);
      return (p + 64'sd536870912) >>> 30;
   endfunction

   cordic_type fin;
   side_type   fs;
   logic signed [32:0] cp, sp, cy, sy;
   assign fin = c_rot[CORDIC_STEPS];
   assign fs  = c_side[CORDIC_STEPS];
   assign cp = fs.pflip ? -fin.px : fin.px;
   assign sp = fs.pflip ? -fin.py : fin.py;
   assign cy = fs.yflip ? -fin.yx : fin.yx;
   assign sy = fs.yflip ? -fin.yy : fin.yy;

   logic               pa_vld_ff;
   logic signed [63:0] pa_rc_ff, pa_rs_ff;
   logic signed [32:0] pa_cy_ff, pa_sy_ff;
   logic [15:0]        pa_inten_ff;
   logic [6:0]         pa_ring_ff;
   always_ff @(posedge clock) begin
      if (reset) pa_vld_ff <= 1'b0;
      else if (adv) pa_vld_ff <= c_vld[CORDIC_STEPS];
      if (adv) begin
         pa_rc_ff <= 64'(signed'({1'b0, fs.range})) * 64'(cp);
         pa_rs_ff <= 64'(signed'({1'b0, fs.range})) * 64'(sp);
         pa_cy_ff <= cy;
         pa_sy_ff <= sy;
         pa_inten_ff <= fs.inten;
         pa_ring_ff <= fs.ring;
      end
   end

   logic               pb_vld_ff;
   logic signed [25:0] pb_rcp_ff, pb_z_ff;
   logic signed [32:0] pb_cy_ff, pb_sy_ff;
   logic [15:0]        pb_inten_ff;
   logic [6:0]         pb_ring_ff;
   always_ff @(posedge clock) begin
      if (reset) pb_vld_ff <= 1'b0;
      else if (adv) pb_vld_ff <= pa_vld_ff;
      if (adv) begin
         pb_rcp_ff <= sat(rnd(pa_rc_ff));
         pb_z_ff   <= sat(rnd(pa_rs_ff));
         pb_cy_ff  <= pa_cy_ff;
         pb_sy_ff  <= pa_sy_ff;
         pb_inten_ff <= pa_inten_ff;
         pb_ring_ff <= pa_ring_ff;
      end
   end

   logic               pc_vld_ff;
   logic signed [63:0] pc_x_ff, pc_y_ff;
   logic signed [25:0] pc_z_ff;
   logic [15:0]        pc_inten_ff;
   logic [6:0]         pc_ring_ff;
   always_ff @(posedge clock) begin
      if (reset) pc_vld_ff <= 1'b0;
      else if (adv) pc_vld_ff <= pb_vld_ff;
      if (adv) begin
         pc_x_ff <= 64'(pb_rcp_ff) * 64'(pb_cy_ff);
         pc_y_ff <= 64'(pb_rcp_ff) * 64'(pb_sy_ff);
         pc_z_ff <= pb_z_ff;
         pc_inten_ff <= pb_inten_ff;
         pc_ring_ff <= pb_ring_ff;
      end
   end

   logic signed [25:0] xo, yo;
   assign xo = sat(rnd(pc_x_ff));
   assign yo = sat(rnd(pc_y_ff));
   always_ff @(posedge clock) begin
      if (reset) out_vld_ff <= 1'b0;
      else if (adv) out_vld_ff <= pc_vld_ff;
      if (adv) begin
         rsp_point_x <= xo[24:0];
         rsp_point_y <= yo[24:0];
         rsp_point_z <= pc_z_ff[24:0];
         rsp_point_intensity <= pc_inten_ff;
         rsp_ring_number <= pc_ring_ff;
      end
   end
   assign rsp_valid = out_vld_ff;

`ifndef SYNTHESIS
   a_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready) else $error("ready while stalled");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result lost");
   a_ring: assert property (@(posedge clock) disable iff (reset)
      ring_ff < 17'(MAX_RINGS) || ring_ff == 17'd0) else $error("ring overflow");
`endif
endmodule
`default_nettype wire
